>>> design/wllc_pkg.sv
// Shared constants and types for the windowed latency level classifier.
package wllc_pkg;

   localparam int WINDOW_DEPTH   = 20;
   localparam int DURATION_BITS  = 20;
   localparam int FIELD_BITS     = 20;
   localparam int LEVEL_BITS     = 3;
   localparam int CSR_INDEX_BITS = 2;

   localparam int COUNT_BITS = $clog2(WINDOW_DEPTH + 1);
   localparam int SLOT_BITS  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int SUM_BITS   = FIELD_BITS + COUNT_BITS;
   localparam int ITER_BITS  = $clog2(SUM_BITS + 1);

   localparam logic [63:0] SAMPLE_MAX = (64'd1 << DURATION_BITS) - 64'd1;

   localparam logic [FIELD_BITS-1:0] LOW_LIMIT_RESET      = FIELD_BITS'(100);
   localparam logic [FIELD_BITS-1:0] MEDIUM_LIMIT_RESET   = FIELD_BITS'(300);
   localparam logic [FIELD_BITS-1:0] HIGH_LIMIT_RESET     = FIELD_BITS'(1000);
   localparam logic [FIELD_BITS-1:0] CRITICAL_LIMIT_RESET = FIELD_BITS'(3000);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOW_LIMIT      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MEDIUM_LIMIT   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIGH_LIMIT     = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CRITICAL_LIMIT = 2'd3;

   localparam logic [LEVEL_BITS-1:0] LEVEL_NONE     = 3'd0;
   localparam logic [LEVEL_BITS-1:0] LEVEL_LOW      = 3'd1;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MEDIUM   = 3'd2;
   localparam logic [LEVEL_BITS-1:0] LEVEL_HIGH     = 3'd3;
   localparam logic [LEVEL_BITS-1:0] LEVEL_CRITICAL = 3'd4;

   // window unit -> sequencer
   typedef struct packed {
      logic                  done;
      logic [SUM_BITS-1:0]   sum;
      logic [COUNT_BITS-1:0] count;
   } wllc_win_rsp_type;

   // sequencer -> divider
   typedef struct packed {
      logic                  start;
      logic [SUM_BITS-1:0]   dividend;
      logic [COUNT_BITS-1:0] divisor;
   } wllc_div_req_type;

   // divider -> sequencer
   typedef struct packed {
      logic                done;
      logic [SUM_BITS-1:0] quotient;
   } wllc_div_rsp_type;

endpackage

>>> design/windowed_latency_level_classifier.sv
// Each accepted beat is one I/O duration sample (saturated to DURATION_BITS)
// and yields one result beat: the truncated average of the last WINDOW_DEPTH
// samples (fewer until the window has filled), a level 0 none .. 4 critical
// from first-match compares of that average against the four limit
// registers, and an active flag for level medium or higher. A sample goes
// from accept to result through these steps: update sum and count (the ring
// slot is read on the accept edge), hand off to the divider, load it, a step
// for each quotient bit of the 25-bit sum, see the divider finish and load
// the output register. req_ready comes back on the edge that loads the
// result, so no new sample is taken before the last result is in the output
// register; a result that finds the output register still full waits in the
// sequencer and holds off the input until rsp_ready frees the register. A
// finished result waits in the output register, so the next sample can be
// taken while rsp_valid is still pending. Limit registers are written
// through csr_ and should only be changed while the block is idle.
module windowed_latency_level_classifier (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [wllc_pkg::FIELD_BITS-1:0]       req_sample_duration,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [wllc_pkg::FIELD_BITS-1:0]       rsp_window_average,
   output logic [wllc_pkg::LEVEL_BITS-1:0]       rsp_level,
   output logic                                  rsp_active,
   input  logic                                  csr_write_enable,
   input  logic [wllc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [wllc_pkg::FIELD_BITS-1:0]       csr_write_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_WINDOW, ST_DIVIDE, ST_HOLD} seq_state_type;

   seq_state_type                    state_ff;
   logic [wllc_pkg::FIELD_BITS-1:0]  low_limit_ff;
   logic [wllc_pkg::FIELD_BITS-1:0]  medium_limit_ff;
   logic [wllc_pkg::FIELD_BITS-1:0]  high_limit_ff;
   logic [wllc_pkg::FIELD_BITS-1:0]  critical_limit_ff;
   logic                             div_start_ff;
   logic                             rsp_valid_ff;
   logic [wllc_pkg::FIELD_BITS-1:0]  average_ff;
   logic [wllc_pkg::LEVEL_BITS-1:0]  level_ff;
   logic                             active_ff;

   logic                             accept;
   logic                             out_free;
   logic [wllc_pkg::FIELD_BITS-1:0]  sample_sat;
   logic [wllc_pkg::FIELD_BITS-1:0]  average_sat;
   logic [wllc_pkg::LEVEL_BITS-1:0]  level_in;

   wllc_pkg::wllc_win_rsp_type       win_status;
   wllc_pkg::wllc_div_req_type       div_req;
   wllc_pkg::wllc_div_rsp_type       div_rsp;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // saturate long durations (only bites when DURATION_BITS < field width)
   always_comb begin
      if (64'(req_sample_duration) > wllc_pkg::SAMPLE_MAX) begin
         sample_sat = wllc_pkg::FIELD_BITS'(wllc_pkg::SAMPLE_MAX);
      end else begin
         sample_sat = req_sample_duration;
      end
   end

   wllc_window u_window (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .sample (sample_sat),
      .status (win_status)
   );

   // sum and count hold still in the window unit until the next sample
   assign div_req.start    = div_start_ff;
   assign div_req.dividend = win_status.sum;
   assign div_req.divisor  = win_status.count;

   wllc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // saturate average to the field, then first-match classify
   always_comb begin
      if (div_rsp.quotient > wllc_pkg::SUM_BITS'({wllc_pkg::FIELD_BITS{1'b1}})) begin
         average_sat = '1;
      end else begin
         average_sat = div_rsp.quotient[wllc_pkg::FIELD_BITS-1:0];
      end
      if (average_sat < low_limit_ff) begin
         level_in = wllc_pkg::LEVEL_NONE;
      end else if (average_sat < medium_limit_ff) begin
         level_in = wllc_pkg::LEVEL_LOW;
      end else if (average_sat < high_limit_ff) begin
         level_in = wllc_pkg::LEVEL_MEDIUM;
      end else if (average_sat < critical_limit_ff) begin
         level_in = wllc_pkg::LEVEL_HIGH;
      end else begin
         level_in = wllc_pkg::LEVEL_CRITICAL;
      end
   end

   // limit registers; index space is exactly the four limits
   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff      <= wllc_pkg::LOW_LIMIT_RESET;
         medium_limit_ff   <= wllc_pkg::MEDIUM_LIMIT_RESET;
         high_limit_ff     <= wllc_pkg::HIGH_LIMIT_RESET;
         critical_limit_ff <= wllc_pkg::CRITICAL_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            wllc_pkg::CSR_LOW_LIMIT:      low_limit_ff      <= csr_write_data;
            wllc_pkg::CSR_MEDIUM_LIMIT:   medium_limit_ff   <= csr_write_data;
            wllc_pkg::CSR_HIGH_LIMIT:     high_limit_ff     <= csr_write_data;
            wllc_pkg::CSR_CRITICAL_LIMIT: critical_limit_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= (state_ff == ST_WINDOW) && win_status.done;
         if ((state_ff == ST_HOLD) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_WINDOW;
               end
            end
            ST_WINDOW: begin
               if (win_status.done) begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (div_rsp.done) begin
                  state_ff <= ST_HOLD;
               end
            end
            ST_HOLD: begin
               // quotient stays put in the divider until the next start
               if (out_free) begin
                  average_ff   <= average_sat;
                  level_ff     <= level_in;
                  active_ff    <= (level_in >= wllc_pkg::LEVEL_MEDIUM);
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_window_average = average_ff;
   assign rsp_level          = level_ff;
   assign rsp_active         = active_ff;

endmodule

>>> design/wllc_window.sv
// Sample ring, running sum, fill count and write slot.
module wllc_window (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [wllc_pkg::FIELD_BITS-1:0]  sample,
   output wllc_pkg::wllc_win_rsp_type       status
);

   logic [wllc_pkg::FIELD_BITS-1:0] sample_ring_ff [wllc_pkg::WINDOW_DEPTH];
   logic [wllc_pkg::FIELD_BITS-1:0] old_ff;
   logic [wllc_pkg::FIELD_BITS-1:0] sample_ff;
   logic [wllc_pkg::SLOT_BITS-1:0]  slot_ff, slot_in;
   logic [wllc_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [wllc_pkg::SUM_BITS-1:0]   sum_ff, sum_in;
   logic                            busy_ff;
   logic                            done_ff;
   logic                            full;

   assign full = (count_ff == wllc_pkg::COUNT_BITS'(wllc_pkg::WINDOW_DEPTH));

   always_comb begin
      if (full) begin
         sum_in   = sum_ff - wllc_pkg::SUM_BITS'(old_ff) + wllc_pkg::SUM_BITS'(sample_ff);
         count_in = count_ff;
      end else begin
         sum_in   = sum_ff + wllc_pkg::SUM_BITS'(sample_ff);
         count_in = count_ff + 1'b1;
      end
      if (slot_ff == wllc_pkg::SLOT_BITS'(wllc_pkg::WINDOW_DEPTH - 1)) begin
         slot_in = '0;
      end else begin
         slot_in = slot_ff + 1'b1;
      end
   end

   // ring: read of the current slot registered, write on the update cycle
   always_ff @(posedge clock) begin
      old_ff <= sample_ring_ff[slot_ff];
      if (busy_ff) begin
         sample_ring_ff[slot_ff] <= sample_ff;
      end
      if (start) begin
         sample_ff <= sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         slot_ff  <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         busy_ff <= start;
         done_ff <= busy_ff;
         if (busy_ff) begin
            slot_ff  <= slot_in;
            count_ff <= count_in;
            sum_ff   <= sum_in;
         end
      end
   end

   assign status.done  = done_ff;
   assign status.sum   = sum_ff;
   assign status.count = count_ff;

endmodule

>>> design/wllc_divider.sv
// Restoring divider, one quotient bit per cycle.
module wllc_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  wllc_pkg::wllc_div_req_type req,
   output wllc_pkg::wllc_div_rsp_type rsp
);

   typedef enum logic {DIV_IDLE, DIV_RUN} div_state_type;

   div_state_type                     state_ff;
   logic [wllc_pkg::SUM_BITS-1:0]     quot_ff;
   logic [wllc_pkg::COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [wllc_pkg::COUNT_BITS-1:0]   divisor_ff;
   logic [wllc_pkg::ITER_BITS-1:0]    iter_ff;
   logic                              done_ff;
   logic [wllc_pkg::COUNT_BITS:0]     shifted;
   logic                              fits;

   always_comb begin
      shifted = {rem_ff, quot_ff[wllc_pkg::SUM_BITS-1]};
      fits    = (shifted >= {1'b0, divisor_ff});
      if (fits) begin
         rem_in = wllc_pkg::COUNT_BITS'(shifted - {1'b0, divisor_ff});
      end else begin
         rem_in = shifted[wllc_pkg::COUNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
         iter_ff  <= '0;
      end else begin
         // last quotient bit goes in on the edge that raises done
         done_ff <= (state_ff == DIV_RUN) && (iter_ff == wllc_pkg::ITER_BITS'(1));
         unique case (state_ff)
            DIV_IDLE: begin
               if (req.start) begin
                  quot_ff    <= req.dividend;
                  divisor_ff <= req.divisor;
                  rem_ff     <= '0;
                  iter_ff    <= wllc_pkg::ITER_BITS'(wllc_pkg::SUM_BITS);
                  state_ff   <= DIV_RUN;
               end
            end
            DIV_RUN: begin
               quot_ff <= {quot_ff[wllc_pkg::SUM_BITS-2:0], fits};
               rem_ff  <= rem_in;
               iter_ff <= iter_ff - 1'b1;
               if (iter_ff == wllc_pkg::ITER_BITS'(1)) begin
                  state_ff <= DIV_IDLE;
               end
            end
            default: state_ff <= DIV_IDLE;
         endcase
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;

endmodule

>>> design/wllc_checker.sv
// Port-level checks for the classifier, bound to the top level.
module wllc_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [wllc_pkg::FIELD_BITS-1:0]       rsp_window_average,
   input logic [wllc_pkg::LEVEL_BITS-1:0]       rsp_level,
   input logic                                  rsp_active
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_window_average)
         && $stable(rsp_level) && $stable(rsp_active))
      else $error("result beat changed while stalled");

   // active flag tracks level
   a_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_active == (rsp_level >= wllc_pkg::LEVEL_MEDIUM)))
      else $error("active flag disagrees with level");

   // level never above critical
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_level <= wllc_pkg::LEVEL_CRITICAL))
      else $error("level out of range");

   // block goes busy after taking a sample
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accept");

endmodule

bind windowed_latency_level_classifier wllc_checker u_wllc_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for the windowed latency level classifier.
`timescale 1ns / 100ps

module testbench;

   localparam int IDLE_LIMIT  = 3000; // cycles with no beat on any port
   localparam int SETTLE      = 40;   // a little over one sample's latency
   localparam int HOLD_CYCLES = 300;  // long result-side hold-off
   localparam int PHASE_BEATS = 205;
   localparam logic [wllc_pkg::FIELD_BITS-1:0] DURATION_MAX  = '1;
   // Average after the beats 0, max, max, 0; re-sending it keeps the average put.
   localparam logic [wllc_pkg::FIELD_BITS-1:0] HELD_AVERAGE =
      wllc_pkg::FIELD_BITS'(wllc_pkg::SAMPLE_MAX / 2);

   typedef struct packed {
      logic [wllc_pkg::FIELD_BITS-1:0] average;
      logic [wllc_pkg::LEVEL_BITS-1:0] level;
      logic                            active;
   } level_report_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [wllc_pkg::FIELD_BITS-1:0]     req_sample_duration = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [wllc_pkg::FIELD_BITS-1:0]     rsp_window_average;
   logic [wllc_pkg::LEVEL_BITS-1:0]     rsp_level;
   logic                                rsp_active;
   logic                                csr_write_enable = 1'b0;
   logic [wllc_pkg::CSR_INDEX_BITS-1:0] csr_index = wllc_pkg::CSR_LOW_LIMIT;
   logic [wllc_pkg::FIELD_BITS-1:0]     csr_write_data = '0;

   windowed_latency_level_classifier i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sample_duration (req_sample_duration),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_window_average  (rsp_window_average),
      .rsp_level           (rsp_level),
      .rsp_active          (rsp_active),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Window predictor: its own ring, running sum, fill count and limits.
   // ------------------------------------------------------------------
   logic [wllc_pkg::FIELD_BITS-1:0] duration_ring [wllc_pkg::WINDOW_DEPTH];
   logic [wllc_pkg::SLOT_BITS-1:0]  ring_slot;
   int unsigned                     ring_fill;
   logic [wllc_pkg::SUM_BITS-1:0]   ring_sum;
   logic [wllc_pkg::FIELD_BITS-1:0] limit_low, limit_medium, limit_high, limit_critical;

   level_report_type predicted_levels [$];
   int unsigned      error_count = 0;

   function automatic level_report_type average_and_classify(
      input logic [wllc_pkg::FIELD_BITS-1:0] duration);
      level_report_type              expected;
      logic [wllc_pkg::SUM_BITS-1:0] mean;
      // Oldest sample drops out only once the window is full.
      if (ring_fill >= wllc_pkg::WINDOW_DEPTH)
         ring_sum = ring_sum - wllc_pkg::SUM_BITS'(duration_ring[ring_slot]);
      else ring_fill++;
      duration_ring[ring_slot] = duration;
      ring_sum = ring_sum + wllc_pkg::SUM_BITS'(duration);
      ring_slot = (ring_slot == wllc_pkg::SLOT_BITS'(wllc_pkg::WINDOW_DEPTH - 1))
                  ? '0 : ring_slot + 1'b1;
      mean = wllc_pkg::SUM_BITS'(ring_sum / ring_fill);
      // First match wins, even when the limits are not in increasing order.
      if (mean < limit_low) expected.level = wllc_pkg::LEVEL_NONE;
      else if (mean < limit_medium) expected.level = wllc_pkg::LEVEL_LOW;
      else if (mean < limit_high) expected.level = wllc_pkg::LEVEL_MEDIUM;
      else if (mean < limit_critical) expected.level = wllc_pkg::LEVEL_HIGH;
      else expected.level = wllc_pkg::LEVEL_CRITICAL;
      expected.average = (mean > wllc_pkg::SUM_BITS'(DURATION_MAX))
                         ? DURATION_MAX : mean[wllc_pkg::FIELD_BITS-1:0];
      expected.active = (expected.level >= wllc_pkg::LEVEL_MEDIUM);
      return expected;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      error_count++;
   endtask

   // Scoreboard: mirrors register writes, predicts each input beat and
   // checks each result beat against the oldest prediction.
   always @(posedge clock) begin
      level_report_type want;
      if (reset) begin
         ring_slot = '0;
         ring_fill = 0;
         ring_sum = '0;
         limit_low = wllc_pkg::LOW_LIMIT_RESET;
         limit_medium = wllc_pkg::MEDIUM_LIMIT_RESET;
         limit_high = wllc_pkg::HIGH_LIMIT_RESET;
         limit_critical = wllc_pkg::CRITICAL_LIMIT_RESET;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               wllc_pkg::CSR_LOW_LIMIT:      limit_low = csr_write_data;
               wllc_pkg::CSR_MEDIUM_LIMIT:   limit_medium = csr_write_data;
               wllc_pkg::CSR_HIGH_LIMIT:     limit_high = csr_write_data;
               wllc_pkg::CSR_CRITICAL_LIMIT: limit_critical = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_levels.size() == 0) begin
               report_mismatch($sformatf("result beat with none expected (avg %0d level %0d)",
                                         rsp_window_average, rsp_level));
            end else begin
               want = predicted_levels.pop_front();
               if (rsp_window_average !== want.average)
                  report_mismatch($sformatf("window_average %0d, expected %0d",
                                            rsp_window_average, want.average));
               if (rsp_level !== want.level)
                  report_mismatch($sformatf("level %0d, expected %0d (avg %0d)",
                                            rsp_level, want.level, want.average));
               if (rsp_active !== want.active)
                  report_mismatch($sformatf("active %0b, expected %0b (level %0d)",
                                            rsp_active, want.active, want.level));
            end
         end
         if (req_valid && req_ready)
            predicted_levels = {predicted_levels,
                                average_and_classify(req_sample_duration)};
      end
   end

   // ------------------------------------------------------------------
   // Result side: stall pattern that changes mode each time the 8-bit phase counter wraps, plus
   // a forced hold-off for the backpressure test.
   // ------------------------------------------------------------------
   logic       hold_results = 1'b0;
   logic [7:0] stall_phase = '0;
   logic [1:0] stall_mode = '0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         stall_phase <= stall_phase + 8'd1;
         if (stall_phase == 8'hFF) stall_mode <= 2'($urandom_range(0, 3));
         if (hold_results) begin
            rsp_ready <= 1'b0;
         end else begin
            case (stall_mode)
               2'd0: rsp_ready <= 1'b1;                    // no stalls
               2'd1: rsp_ready <= 1'($urandom_range(0, 1)); // coin flip
               2'd2: rsp_ready <= (stall_phase[2:0] == 3'd0);
               default: rsp_ready <= stall_phase[5];        // stretches set by phase bit 5
            endcase
         end
      end
   end

   // Watchdog: ends the run if nothing moves for too long.
   int unsigned idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Input side: random-length bursts with random gaps, or steady when sender_steady.
   // ------------------------------------------------------------------
   bit          sender_steady = 1'b0;
   int unsigned burst_left = 1;

   task automatic send_sample(input logic [wllc_pkg::FIELD_BITS-1:0] duration);
      req_valid <= 1'b1;
      req_sample_duration <= duration;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!sender_steady) begin
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 70)) @(posedge clock);
         end
      end
   endtask

   task automatic idle_input();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Limits change only with the block idle: every result back first.
   task automatic write_limits(input logic [wllc_pkg::FIELD_BITS-1:0] low_limit, mid_limit,
                               high_limit, critical_limit);
      idle_input();
      while (predicted_levels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= wllc_pkg::CSR_LOW_LIMIT;
      csr_write_data <= low_limit;
      @(posedge clock);
      csr_index <= wllc_pkg::CSR_MEDIUM_LIMIT;
      csr_write_data <= mid_limit;
      @(posedge clock);
      csr_index <= wllc_pkg::CSR_HIGH_LIMIT;
      csr_write_data <= high_limit;
      @(posedge clock);
      csr_index <= wllc_pkg::CSR_CRITICAL_LIMIT;
      csr_write_data <= critical_limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Durations that wander around a moving target so the window average
   // sweeps through the bands; a few extremes and full-range noise mixed in.
   task automatic run_traffic(input int unsigned beats, input int span);
      int target = 0;
      int segment_left = 0;
      int jitter;
      int value;
      for (int unsigned n = 0; n < beats; n++) begin
         if (segment_left == 0) begin
            target = $urandom_range(0, span);
            segment_left = $urandom_range(8, 40);
         end
         segment_left--;
         jitter = span / 8;
         case ($urandom_range(0, 19))
            0: value = 0;
            1: value = int'(DURATION_MAX);
            2, 3: value = int'(wllc_pkg::FIELD_BITS'($urandom()));
            default: begin
               value = target + int'($urandom_range(0, 2 * jitter)) - jitter;
               if (value < 0) value = 0;
               if (value > span) value = span;
            end
         endcase
         send_sample(wllc_pkg::FIELD_BITS'(value));
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic apply_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
   endtask

   // Field extremes under the reset limits, first beats of an empty window.
   task automatic test_duration_extremes();
      send_sample('0);
      send_sample(DURATION_MAX);
      send_sample(DURATION_MAX);
      send_sample('0);
   endtask

   // Average held fixed; limits placed on it so each level is hit with the
   // average on the band's lower limit, or just below the low limit for none.
   task automatic test_level_bands();
      logic [wllc_pkg::FIELD_BITS-1:0] at, above;
      at = HELD_AVERAGE;
      above = HELD_AVERAGE + wllc_pkg::FIELD_BITS'(1);
      for (int lvl = 0; lvl <= 4; lvl++) begin
         write_limits(lvl > 0 ? at : above, lvl > 1 ? at : above,
                      lvl > 2 ? at : above, lvl > 3 ? at : above);
         send_sample(HELD_AVERAGE);
      end
   endtask

   // Limits out of order: first match still decides.
   task automatic test_unordered_limits();
      write_limits(wllc_pkg::FIELD_BITS'(600000), wllc_pkg::FIELD_BITS'(10), DURATION_MAX, '0);
      send_sample(HELD_AVERAGE);
      write_limits('0, DURATION_MAX, '0, DURATION_MAX);
      send_sample(HELD_AVERAGE);
      write_limits(wllc_pkg::FIELD_BITS'(100), '0, DURATION_MAX, '0);
      send_sample(HELD_AVERAGE);
   endtask

   // Fill the window and wrap the ring; all-zero limits force critical.
   task automatic test_window_wrap();
      write_limits('0, '0, '0, '0);
      repeat (10) send_sample(DURATION_MAX);
   endtask

   // Random phases under several limit settings, extremes among them.
   task automatic test_random_phases();
      int span;
      logic [wllc_pkg::FIELD_BITS-1:0] l0, l1, l2, l3;
      for (int phase = 0; phase < 9; phase++) begin
         span = (1 << $urandom_range(8, 20)) - 1;
         l0 = wllc_pkg::FIELD_BITS'($urandom_range(0, span / 4));
         l1 = l0 + wllc_pkg::FIELD_BITS'($urandom_range(0, span / 4));
         l2 = l1 + wllc_pkg::FIELD_BITS'($urandom_range(0, span / 4));
         l3 = l2 + wllc_pkg::FIELD_BITS'($urandom_range(0, span / 4));
         sender_steady = (phase == 8);
         case (phase)
            0: begin
               span = 4000;
               write_limits(wllc_pkg::LOW_LIMIT_RESET, wllc_pkg::MEDIUM_LIMIT_RESET,
                            wllc_pkg::HIGH_LIMIT_RESET, wllc_pkg::CRITICAL_LIMIT_RESET);
            end
            2: write_limits('0, '0, '0, '0);
            3: begin
               span = int'(DURATION_MAX);
               write_limits(DURATION_MAX, DURATION_MAX, DURATION_MAX, DURATION_MAX);
            end
            7: write_limits(wllc_pkg::FIELD_BITS'($urandom()), wllc_pkg::FIELD_BITS'($urandom()),
                            wllc_pkg::FIELD_BITS'($urandom()), wllc_pkg::FIELD_BITS'($urandom()));
            default: write_limits(l0, l1, l2, l3);
         endcase
         run_traffic(PHASE_BEATS, span);
      end
      sender_steady = 1'b0;
   endtask

   // Result side held off while samples keep coming: the output register
   // fills, then the block must stall its input without losing a beat.
   task automatic test_result_backpressure();
      write_limits(wllc_pkg::LOW_LIMIT_RESET, wllc_pkg::MEDIUM_LIMIT_RESET,
                   wllc_pkg::HIGH_LIMIT_RESET, wllc_pkg::CRITICAL_LIMIT_RESET);
      sender_steady = 1'b1;
      fork
         begin
            hold_results <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_results <= 1'b0;
         end
         run_traffic(80, 4000);
      join
      sender_steady = 1'b0;
   endtask

   initial begin
      apply_reset();
      test_duration_extremes();
      test_level_bands();
      test_unordered_limits();
      test_window_wrap();
      test_result_backpressure();
      test_random_phases();
      idle_input();
      while (predicted_levels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
